### hdl/mp_pkg.sv
// shared constants and types for the modular power block
package mp_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int FIELD_W       = 64;
	localparam int CFG_DATA_W    = 64;
	localparam int PADDR_W       = 4;

	localparam logic [CFG_DATA_W-1:0] MODULUS_RESET = 64'd1000000007;

	// register index taken from paddr[3]
	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_WRAP    = 1'b1;

	typedef struct packed {
		logic start;
		logic wrap;
	} mul_ctl_t;

endpackage

### hdl/mp_serial_mul.sv
// bit-serial multiplier: r = a * b mod m, or mod 2^W in wrap mode, one bit of b per cycle
module mp_serial_mul #(
	parameter int W = mp_pkg::WORD_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mp_pkg::mul_ctl_t ctl,
	input  logic [W-1:0]    modulus,
	input  logic [W-1:0]    a_in,
	input  logic [W-1:0]    b_in,
	output logic [W-1:0]    r,
	output logic            done
);
	import mp_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          wrap_q;

	logic [W+1:0]  t;
	logic [W+1:0]  m1;
	logic [W+1:0]  m2;
	logic [W-1:0]  r_nxt;

	// double, add the partial product, then fold back below the modulus
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
		m1 = {2'b00, modulus};
		m2 = {1'b0, modulus, 1'b0};
		if (wrap_q) begin
			r_nxt = t[W-1:0];
		end else if (t >= m2) begin
			r_nxt = W'(t - m2);
		end else if (t >= m1) begin
			r_nxt = W'(t - m1);
		end else begin
			r_nxt = t[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			a_q    <= a_in;
			b_q    <= b_in;
			r_q    <= '0;
			wrap_q <= ctl.wrap;
		end else if (busy_q) begin
			r_q <= r_nxt;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign r    = r_q;
	assign done = done_q;

endmodule

### hdl/modular_power.sv
// modular power top level: right-to-left square and multiply over two serial multipliers
// sequence: the base is reduced first, then one square-and-multiply round runs per exponent
// bit up to the highest set bit, then the result is posted
// throughput: one item at a time, set by the bit-serial multipliers (one bit of b a cycle),
// squaring and multiply of a round side by side; a stalled result holds back the next one
// reset: asynchronous, modulus 1000000007, modular mode, idle with no result pending
module modular_power #(
	parameter int WORD_BITS = mp_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mp_pkg::FIELD_W-1:0]       base_value,
	input  logic [mp_pkg::FIELD_W-1:0]       exponent,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mp_pkg::FIELD_W-1:0]       power_result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mp_pkg::PADDR_W-1:0]       paddr,
	input  logic [mp_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [mp_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                             pready
);
	import mp_pkg::*;

	localparam int W = WORD_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RED    = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]            state_q;
	logic [CFG_DATA_W-1:0] modulus_q;
	logic                  wrap_q;
	logic [W-1:0]          acc_q;
	logic [W-1:0]          sq_q;
	logic [W-1:0]          exp_q;
	logic [FIELD_W-1:0]    result_q;
	logic                  out_valid_q;

	logic [W-1:0] m_w;
	logic         wrap_eff;
	logic         in_acc;
	logic         cfg_wr;
	logic         res_load;
	mul_ctl_t     ctl0;
	mul_ctl_t     ctl1;
	logic [W-1:0] a0;
	logic [W-1:0] b0;
	logic [W-1:0] r0;
	logic [W-1:0] r1;
	logic         done0;
	logic         done1;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[3] == REG_WRAP) ? CFG_DATA_W'(wrap_q) : modulus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			wrap_q    <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_WRAP) begin
				wrap_q <= pwdata[0];
			end else begin
				modulus_q <= pwdata;
			end
		end
	end

	// zero modulus falls back to wrap mode
	assign m_w      = modulus_q[W-1:0];
	assign wrap_eff = wrap_q || (m_w == '0);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign res_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// first pass reduces the base as 1 * base
	assign a0 = (state_q == ST_IDLE) ? W'(1) : acc_q;
	assign b0 = (state_q == ST_IDLE) ? base_value[W-1:0] : sq_q;

	always_comb begin
		ctl0.start = in_acc || (state_q == ST_LAUNCH);
		ctl0.wrap  = wrap_eff;
		ctl1.start = (state_q == ST_LAUNCH);
		ctl1.wrap  = wrap_eff;
	end

	mp_serial_mul #(.W(W)) u_mul_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl0),
		.modulus (m_w),
		.a_in    (a0),
		.b_in    (b0),
		.r       (r0),
		.done    (done0)
	);

	mp_serial_mul #(.W(W)) u_mul_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl1),
		.modulus (m_w),
		.a_in    (sq_q),
		.b_in    (sq_q),
		.r       (r1),
		.done    (done1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (done0) begin
						state_q <= (exp_q == '0) ? ST_DONE : ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (done0 && done1) begin
						state_q <= (exp_q[W-1:1] == '0) ? ST_DONE : ST_LAUNCH;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			exp_q <= exponent[W-1:0];
			acc_q <= W'(1);
		end
		if (state_q == ST_RED && done0) begin
			sq_q <= r0;
		end
		if (state_q == ST_RUN && done0 && done1) begin
			if (exp_q[0]) begin
				acc_q <= r0;
			end
			sq_q  <= r1;
			exp_q <= exp_q >> 1;
		end
		if (res_load) begin
			result_q <= FIELD_W'(acc_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign power_result = result_q;

endmodule

### hdl/mp_checker.sv
// port-level checks for the modular power block and the bind that attaches them
module mp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mp_pkg::FIELD_W-1:0]    power_result,
	input logic                          pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(power_result))
		else $error("result changed or dropped while stalled");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an item was taken");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result shown without a busy period before it");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind modular_power mp_checker u_mp_checker (.*);

### dv/modular_power_tb.sv
// self-checking testbench for the modular power block: directed table, then random phases
module modular_power_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mp_pkg::*;

	localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MRST = MODULUS_RESET;
	localparam logic [63:0] TOPB = 64'h8000_0000_0000_0000;
	localparam int QUIET_LIMIT = 60000;
	localparam int LONG_HOLD = 2500;
	localparam int DIR_ROWS = 23;
	localparam int RAND_PHASES = 7;
	localparam int PHASE_ITEMS = 17;

	typedef struct {
		logic [63:0] modulus;
		logic        wrap;
		logic [63:0] base;
		logic [63:0] expo;
		bit          known;
		logic [63:0] power;
	} power_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FIELD_W-1:0] base_value = '0;
	logic [FIELD_W-1:0] exponent = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FIELD_W-1:0] power_result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	logic [63:0] expected_powers[$];
	logic [63:0] cfg_modulus = MRST;
	logic        cfg_wrap = 1'b0;

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_applied = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	logic [63:0] oldest_power;

	power_row_t power_table [DIR_ROWS] = '{
		'{MRST, 1'b0, 64'd0, 64'd0, 1'b1, 64'd1},
		'{MRST, 1'b0, MAXV, 64'd0, 1'b1, 64'd1},
		'{MRST, 1'b0, 64'd2, 64'd10, 1'b1, 64'd1024},
		'{MRST, 1'b0, 64'd0, 64'd5, 1'b1, 64'd0},
		'{MRST, 1'b0, MAXV, MAXV, 1'b0, 64'd0},
		'{MRST, 1'b0, MRST, 64'd1, 1'b1, 64'd0},
		'{MRST, 1'b0, MRST + 64'd1, 64'd1, 1'b1, 64'd1},
		'{MRST, 1'b0, 64'd3, 64'd1, 1'b1, 64'd3},
		'{64'd1, 1'b0, 64'd5, 64'd0, 1'b1, 64'd1},
		'{64'd1, 1'b0, 64'd5, 64'd7, 1'b1, 64'd0},
		'{64'd1, 1'b0, MAXV, MAXV, 1'b1, 64'd0},
		'{MAXV, 1'b0, MAXV, 64'd1, 1'b1, 64'd0},
		'{MAXV, 1'b0, MAXV - 64'd1, 64'd2, 1'b1, 64'd1},
		'{MAXV, 1'b0, TOPB, 64'd3, 1'b0, 64'd0},
		'{64'd0, 1'b0, 64'd2, 64'd63, 1'b1, TOPB},
		'{64'd0, 1'b0, 64'd2, 64'd64, 1'b1, 64'd0},
		'{64'd0, 1'b0, 64'd3, MAXV, 1'b0, 64'd0},
		'{64'd7, 1'b1, MAXV, 64'd2, 1'b1, 64'd1},
		'{64'd7, 1'b1, MAXV, 64'd3, 1'b1, MAXV},
		'{64'd7, 1'b1, 64'd7, 64'd2, 1'b1, 64'd49},
		'{64'd7, 1'b1, 64'd0, 64'd0, 1'b1, 64'd1},
		'{64'd2, 1'b0, MAXV, MAXV, 1'b1, 64'd1},
		'{64'd2, 1'b0, 64'd4, 64'd1, 1'b1, 64'd0}
	};

	modular_power dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.base_value(base_value),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.power_result(power_result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] mul_step(input logic [63:0] a, input logic [63:0] b,
			input logic use_wrap, input logic [63:0] m);
		logic [127:0] full;
		full = {64'd0, a} * {64'd0, b};
		if (use_wrap) begin
			return full[63:0];
		end
		full = full % {64'd0, m};
		return full[63:0];
	endfunction

	function automatic logic [63:0] predict_power(input logic [63:0] base, input logic [63:0] expo);
		logic use_wrap;
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] left;
		use_wrap = cfg_wrap || (cfg_modulus == 64'd0);
		acc = 64'd1;
		sq = base;
		left = expo;
		for (int n = 0; n < 64 && left != 64'd0; n++) begin
			if (left[0]) begin
				acc = mul_step(acc, sq, use_wrap, cfg_modulus);
			end
			sq = mul_step(sq, sq, use_wrap, cfg_modulus);
			left = left >> 1;
		end
		return acc;
	endfunction

	task automatic cfg_write(input logic idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MODULUS) begin
			cfg_modulus = value;
		end else begin
			cfg_wrap = value[0];
		end
		@(posedge clk);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_powers.size() != 0) @(posedge clk);
	endtask

	// offer one item, then either keep the burst going or idle for a while
	task automatic push_item(input logic [63:0] b, input logic [63:0] e, input logic [63:0] want);
		in_valid <= 1'b1;
		base_value <= b;
		exponent <= e;
		do @(posedge clk); while (in_stall);
		expected_powers.insert(expected_powers.size(), want);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_powers.size() == 0) begin
					errors++;
					$display("%0t power_result %h arrived with no item outstanding", $time,
						power_result);
				end else begin
					oldest_power = expected_powers.pop_front();
					if (power_result !== oldest_power) begin
						errors++;
						$display("%0t power_result mismatch: expected %h, actual %h", $time,
							oldest_power, power_result);
					end
				end
			end
		end
		if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 300);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t no item moved for %0d cycles", $time, quiet_cycles);
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [63:0] mod_pick;
		logic        wrap_pick;
		logic [63:0] b;
		logic [63:0] e;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (power_table[i].modulus !== cfg_modulus || power_table[i].wrap !== cfg_wrap) begin
				wait_all_results();
				if (power_table[i].modulus !== cfg_modulus) begin
					cfg_write(REG_MODULUS, power_table[i].modulus);
				end
				if (power_table[i].wrap !== cfg_wrap) begin
					cfg_write(REG_WRAP, {63'd0, power_table[i].wrap});
				end
				settings_applied++;
			end
			push_item(power_table[i].base, power_table[i].expo,
				power_table[i].known ? power_table[i].power
				: predict_power(power_table[i].base, power_table[i].expo));
		end

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: begin mod_pick = {$urandom, $urandom}; wrap_pick = 1'b0; end
				1: begin mod_pick = 64'($urandom_range(1, 65535)); wrap_pick = 1'b0; end
				2: begin mod_pick = {$urandom, $urandom}; wrap_pick = 1'b1; end
				3: begin mod_pick = MAXV; wrap_pick = 1'b0; end
				4: begin mod_pick = 64'($urandom_range(1, 3)); wrap_pick = 1'b0; end
				5: begin mod_pick = 64'd0; wrap_pick = 1'b0; end
				default: begin
					mod_pick = {1'b1, 31'($urandom), $urandom};
					wrap_pick = 1'($urandom_range(0, 1));
				end
			endcase
			wait_all_results();
			cfg_write(REG_MODULUS, mod_pick);
			cfg_write(REG_WRAP, {63'd0, wrap_pick});
			settings_applied++;
			if (phase == 0) begin
				hold_request = 1'b1;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(0, 9))
					0: b = 64'd0;
					1: b = MAXV;
					2: b = cfg_modulus;
					3: b = cfg_modulus - 64'd1;
					4: b = 64'($urandom_range(0, 15));
					default: b = {$urandom, $urandom};
				endcase
				// mostly short exponents to keep the run quick, some full width
				case ($urandom_range(0, 9))
					0: e = 64'd0;
					1: e = {$urandom, $urandom};
					2: e = 64'd1 << $urandom_range(0, 15);
					default: e = 64'($urandom_range(1, 1023));
				endcase
				push_item(b, e, predict_power(b, e));
				if (phase == 3 && k == 9) begin
					wait_all_results();
				end
			end
		end

		wait_all_results();
		repeat (200) @(posedge clk);
		$display("covered %0d items and %0d results over %0d register settings", items_sent,
			results_seen, settings_applied);
		$display("modes: reset, modulus one, zero and max, wrap, small and random moduli");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
